[hw/rtl/npfp_pkg.sv]
`default_nettype none

package npfp_pkg;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_START = 2'd1,
		OP_DUMP  = 2'd2,
		OP_SPARE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SKIP,
		PH_FIELDS
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_RMC,
		KIND_GGA,
		KIND_GLL
	} kind_t;

	typedef enum logic [2:0] {
		ROLE_NONE,
		ROLE_TIME,
		ROLE_STATUS,
		ROLE_LAT,
		ROLE_NS,
		ROLE_LON,
		ROLE_EW
	} role_t;

	typedef struct packed {
		logic wr_en;
		logic wr_lon;
		logic clr_time;
	} store_cmd_t;

	typedef struct packed {
		logic north;
		logic east;
		logic fix_ready;
	} flags_t;

	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int SKIP_BYTES     = 3;
	localparam int TIME_LEAD      = 4;
	localparam int FIELD_COUNT    = 7;
	localparam int LEN_MAX        = 15;
	localparam int DUMP_PER_STORE = 16;
	localparam int DUMP_TOTAL     = 2 * DUMP_PER_STORE;
	localparam int CLR_LAT_LO     = 2;
	localparam int CLR_HI         = 10;

	function automatic role_t field_role(kind_t kind, logic [2:0] field);
		role_t r;
		r = ROLE_NONE;
		case (kind)
			KIND_RMC: begin
				case (field)
					3'd1: r = ROLE_TIME;
					3'd2: r = ROLE_STATUS;
					3'd3: r = ROLE_LAT;
					3'd4: r = ROLE_NS;
					3'd5: r = ROLE_LON;
					3'd6: r = ROLE_EW;
					default: r = ROLE_NONE;
				endcase
			end
			KIND_GGA: begin
				case (field)
					3'd1: r = ROLE_TIME;
					3'd2: r = ROLE_LAT;
					3'd3: r = ROLE_NS;
					3'd4: r = ROLE_LON;
					3'd5: r = ROLE_EW;
					default: r = ROLE_NONE;
				endcase
			end
			KIND_GLL: begin
				case (field)
					3'd1: r = ROLE_LAT;
					3'd2: r = ROLE_NS;
					3'd3: r = ROLE_LON;
					3'd4: r = ROLE_EW;
					default: r = ROLE_NONE;
				endcase
			end
			default: r = ROLE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] to_digit(logic [7:0] c);
		logic [3:0] d;
		d = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = 4'(c - CH_ZERO);
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/npfp_if.sv]
`default_nettype none

interface npfp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface npfp_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] digit;
	logic [4:0] slot_index;
	logic       last;
	logic       north;
	logic       east;
	logic       fix_ready;

	modport source (
		output valid, output digit, output slot_index, output last,
		output north, output east, output fix_ready, input ready
	);
	modport sink (
		input valid, input digit, input slot_index, input last,
		input north, input east, input fix_ready, output ready
	);
endinterface

`default_nettype wire

[hw/rtl/npfp_parser.sv]
`default_nettype none

module npfp_parser #(
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	npfp_in_if.sink                           sentence,
	input  wire logic                         dump_busy,
	output logic                              dump_start,
	output npfp_pkg::store_cmd_t              cmd,
	output logic [$clog2(DIGIT_SLOTS)-1:0]    wr_slot,
	output logic [3:0]                        wr_digit,
	output npfp_pkg::flags_t                  flags
);

	localparam int SLOT_W = $clog2(DIGIT_SLOTS);
	localparam int WS_W   = $clog2(DIGIT_SLOTS + 1);

	logic                 valid_s1;
	npfp_pkg::opcode_t    opcode_s1;
	logic [7:0]           byte_s1;

	npfp_pkg::phase_t     phase_q, phase_d;
	logic [1:0]           skip_q, skip_d;
	npfp_pkg::kind_t      kind_q, kind_d;
	logic [2:0]           field_q, field_d;
	logic [3:0]           len_q, len_d;
	logic [7:0]           first_q, first_d;
	logic [WS_W-1:0]      ws_q, ws_d;
	logic                 north_q, north_d;
	logic                 east_q, east_d;
	logic                 ready_q, ready_d;

	logic                 is_byte, is_start;
	logic                 field_end, skip_done, status_stop, last_field, want_store;
	npfp_pkg::role_t      role;
	npfp_pkg::kind_t      kind_dec;

	assign sentence.ready = !dump_busy && !(valid_s1 && opcode_s1 == npfp_pkg::OP_DUMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= sentence.valid && sentence.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (sentence.valid && sentence.ready) begin
			opcode_s1 <= npfp_pkg::opcode_t'(sentence.opcode);
			byte_s1   <= sentence.data_byte;
		end
	end

	assign is_byte    = valid_s1 && opcode_s1 == npfp_pkg::OP_BYTE;
	assign is_start   = valid_s1 && opcode_s1 == npfp_pkg::OP_START;
	assign dump_start = valid_s1 && opcode_s1 == npfp_pkg::OP_DUMP;

	assign role        = npfp_pkg::field_role(kind_q, field_q);
	assign field_end   = byte_s1 == npfp_pkg::CH_COMMA || byte_s1 == npfp_pkg::CH_NUL;
	assign skip_done   = skip_q == 2'(npfp_pkg::SKIP_BYTES);
	assign status_stop = len_q != 4'd0 && role == npfp_pkg::ROLE_STATUS
		&& first_q != npfp_pkg::CH_A;
	assign last_field  = field_q == 3'(npfp_pkg::FIELD_COUNT - 1);

	always_comb begin
		kind_d = npfp_pkg::KIND_NONE;
		unique case (byte_s1)
			npfp_pkg::CH_M: kind_d = npfp_pkg::KIND_RMC;
			npfp_pkg::CH_G: kind_d = npfp_pkg::KIND_GGA;
			npfp_pkg::CH_L: kind_d = npfp_pkg::KIND_GLL;
			default:        kind_d = npfp_pkg::KIND_NONE;
		endcase
		kind_dec = kind_d;
		if (is_start) begin
			kind_d = npfp_pkg::KIND_NONE;
		end else if (!(is_byte && phase_q == npfp_pkg::PH_SKIP && skip_done)) begin
			kind_d = kind_q;
		end
	end

	// store a lat/lon/time character: '.' dropped, writes past the end dropped
	assign want_store = is_byte && phase_q == npfp_pkg::PH_FIELDS && !field_end
		&& (role == npfp_pkg::ROLE_LAT || role == npfp_pkg::ROLE_LON
		|| (role == npfp_pkg::ROLE_TIME && len_q >= 4'(npfp_pkg::TIME_LEAD)))
		&& byte_s1 != npfp_pkg::CH_DOT
		&& ws_q < WS_W'(DIGIT_SLOTS);

	always_comb begin
		phase_d = phase_q;
		if (is_start) begin
			phase_d = npfp_pkg::PH_SKIP;
		end else if (is_byte) begin
			unique case (phase_q)
				npfp_pkg::PH_SKIP: begin
					if (skip_done) begin
						phase_d = (kind_dec == npfp_pkg::KIND_NONE) ?
							npfp_pkg::PH_IDLE : npfp_pkg::PH_FIELDS;
					end
				end
				npfp_pkg::PH_FIELDS: begin
					if (field_end && (status_stop || last_field)) begin
						phase_d = npfp_pkg::PH_IDLE;
					end
				end
				npfp_pkg::PH_IDLE: phase_d = npfp_pkg::PH_IDLE;
				default:           phase_d = npfp_pkg::PH_IDLE;
			endcase
		end
	end

	always_comb begin
		skip_d  = skip_q;
		field_d = field_q;
		len_d   = len_q;
		first_d = first_q;
		ws_d    = ws_q;
		north_d = north_q;
		east_d  = east_q;
		ready_d = ready_q;

		cmd.wr_en    = want_store;
		cmd.wr_lon   = role == npfp_pkg::ROLE_LON;
		cmd.clr_time = is_byte && phase_q == npfp_pkg::PH_FIELDS && field_end
			&& len_q != 4'd0 && role == npfp_pkg::ROLE_TIME;
		wr_slot      = ws_q[SLOT_W-1:0];
		wr_digit     = npfp_pkg::to_digit(byte_s1);

		if (is_start) begin
			skip_d  = 2'd0;
			field_d = 3'd0;
			len_d   = 4'd0;
			first_d = 8'd0;
			ws_d    = '0;
		end else if (is_byte && phase_q == npfp_pkg::PH_SKIP) begin
			if (!skip_done) begin
				skip_d = skip_q + 2'd1;
			end else begin
				field_d = 3'd0;
				len_d   = 4'd0;
				first_d = 8'd0;
				ws_d    = '0;
			end
		end else if (is_byte && phase_q == npfp_pkg::PH_FIELDS) begin
			if (field_end) begin
				if (len_q != 4'd0 && role == npfp_pkg::ROLE_NS) begin
					north_d = first_q == npfp_pkg::CH_N;
				end
				if (len_q != 4'd0 && role == npfp_pkg::ROLE_EW) begin
					east_d = first_q == npfp_pkg::CH_E;
				end
				if (status_stop) begin
					ready_d = 1'b1;
				end else begin
					field_d = field_q + 3'd1;
					len_d   = 4'd0;
					first_d = 8'd0;
					ws_d    = '0;
					if (last_field) begin
						ready_d = 1'b1;
					end
				end
			end else begin
				if (len_q == 4'd0) begin
					first_d = byte_s1;
				end
				if (want_store) begin
					ws_d = ws_q + WS_W'(1);
				end
				if (len_q != 4'(npfp_pkg::LEN_MAX)) begin
					len_d = len_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= npfp_pkg::PH_IDLE;
			skip_q  <= 2'd0;
			kind_q  <= npfp_pkg::KIND_NONE;
			field_q <= 3'd0;
			len_q   <= 4'd0;
			first_q <= 8'd0;
			ws_q    <= '0;
			north_q <= 1'b0;
			east_q  <= 1'b0;
			ready_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			kind_q  <= kind_d;
			field_q <= field_d;
			len_q   <= len_d;
			first_q <= first_d;
			ws_q    <= ws_d;
			north_q <= north_d;
			east_q  <= east_d;
			ready_q <= ready_d;
		end
	end

	assign flags.north     = north_q;
	assign flags.east      = east_q;
	assign flags.fix_ready = ready_q;

endmodule

`default_nettype wire

[hw/rtl/npfp_store.sv]
`default_nettype none

module npfp_store #(
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire npfp_pkg::store_cmd_t          cmd,
	input  wire logic [$clog2(DIGIT_SLOTS)-1:0] wr_slot,
	input  wire logic [3:0]                    wr_digit,
	input  wire logic                          rd_lon,
	input  wire logic [$clog2(DIGIT_SLOTS)-1:0] rd_slot,
	output logic [3:0]                         rd_digit
);

	logic [3:0] lat_q [DIGIT_SLOTS];
	logic [3:0] lon_q [DIGIT_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIGIT_SLOTS; k++) begin
				lat_q[k] <= 4'd0;
				lon_q[k] <= 4'd0;
			end
		end else begin
			// a finished non-empty time field wipes lat slots 2..10 and lon slots 0..10
			if (cmd.clr_time) begin
				for (int k = 0; k < DIGIT_SLOTS; k++) begin
					if (k >= npfp_pkg::CLR_LAT_LO && k <= npfp_pkg::CLR_HI) begin
						lat_q[k] <= 4'd0;
					end
					if (k <= npfp_pkg::CLR_HI) begin
						lon_q[k] <= 4'd0;
					end
				end
			end
			if (cmd.wr_en) begin
				if (cmd.wr_lon) begin
					lon_q[wr_slot] <= wr_digit;
				end else begin
					lat_q[wr_slot] <= wr_digit;
				end
			end
		end
	end

	assign rd_digit = rd_lon ? lon_q[rd_slot] : lat_q[rd_slot];

endmodule

`default_nettype wire

[hw/rtl/npfp_dump.sv]
`default_nettype none

module npfp_dump #(
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire npfp_pkg::flags_t              flags,
	output logic                               busy,
	output logic                               rd_lon,
	output logic [$clog2(DIGIT_SLOTS)-1:0]     rd_slot,
	input  wire logic [3:0]                    rd_digit,
	npfp_out_if.source                         result
);

	localparam int SLOT_W = $clog2(DIGIT_SLOTS);

	logic       busy_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic [3:0] digit_q;
	logic [4:0] slot_q;
	logic       last_q;
	logic       north_q, east_q, fix_q;

	logic [3:0] s;
	logic       in_range, last_item, load;

	assign s         = cnt_q[3:0];
	assign in_range  = int'(s) < DIGIT_SLOTS;
	assign last_item = cnt_q == 5'(npfp_pkg::DUMP_TOTAL - 1);
	assign load      = busy_q && (!out_valid_q || result.ready);

	assign rd_lon  = cnt_q[4];
	assign rd_slot = SLOT_W'(s);
	assign busy    = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (load) begin
				cnt_q <= cnt_q + 5'd1;
				if (last_item) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digit_q <= in_range ? rd_digit : 4'd0;
			slot_q  <= cnt_q;
			last_q  <= last_item;
			north_q <= flags.north;
			east_q  <= flags.east;
			fix_q   <= flags.fix_ready;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.digit      = digit_q;
	assign result.slot_index = slot_q;
	assign result.last       = last_q;
	assign result.north      = north_q;
	assign result.east       = east_q;
	assign result.fix_ready  = fix_q;

endmodule

`default_nettype wire

[hw/rtl/nmea_position_field_parser_core.sv]
// Position field parser for NMEA sentences. Each word on the sentence channel is a sentence
// byte, a start mark or a dump command; bytes and starts are taken one per cycle, back to
// back, and act on the parser in the cycle after acceptance via a single input register.
// A dump streams 32 words (latitude slots 0..15, then longitude slots 0..15, last on the
// final one) through a one-word output register, one per cycle while the sink takes them;
// the sentence channel is held off from the cycle after the dump is taken until its last
// digit is loaded into the output register.
`default_nettype none

module nmea_position_field_parser_core #(
	parameter int DIGIT_SLOTS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	npfp_in_if.sink    sentence,
	npfp_out_if.source result
);

	localparam int SLOT_W = $clog2(DIGIT_SLOTS);

	npfp_pkg::store_cmd_t cmd;
	npfp_pkg::flags_t     flags;
	logic [SLOT_W-1:0]    wr_slot, rd_slot;
	logic [3:0]           wr_digit, rd_digit;
	logic                 rd_lon;
	logic                 dump_start, dump_busy;

	npfp_parser #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.sentence   (sentence),
		.dump_busy  (dump_busy),
		.dump_start (dump_start),
		.cmd        (cmd),
		.wr_slot    (wr_slot),
		.wr_digit   (wr_digit),
		.flags      (flags)
	);

	npfp_store #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_slot  (wr_slot),
		.wr_digit (wr_digit),
		.rd_lon   (rd_lon),
		.rd_slot  (rd_slot),
		.rd_digit (rd_digit)
	);

	npfp_dump #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_dump (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dump_start),
		.flags    (flags),
		.busy     (dump_busy),
		.rd_lon   (rd_lon),
		.rd_slot  (rd_slot),
		.rd_digit (rd_digit),
		.result   (result)
	);

endmodule

`default_nettype wire

[hw/rtl/npfp_checker.sv]
`default_nettype none

module npfp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] in_opcode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] out_digit,
	input wire logic [4:0] out_slot_index,
	input wire logic       out_last
);

	// a dump word closes the sentence channel right after it is taken
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == npfp_pkg::OP_DUMP |=> !in_ready)
		else $error("sentence channel open right after a dump word");

	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last
		|=> out_valid && out_slot_index == $past(out_slot_index) + 5'd1)
		else $error("dump words not contiguous");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_last == (out_slot_index == 5'(npfp_pkg::DUMP_TOTAL - 1)))
		else $error("last flag on wrong slot");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_digit <= 4'd9)
		else $error("stored digit out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_slot_index) && $stable(out_digit))
		else $error("stalled result word changed");

endmodule

bind nmea_position_field_parser_core npfp_checker u_npfp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sentence.valid),
	.in_ready       (sentence.ready),
	.in_opcode      (sentence.opcode),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_digit      (result.digit),
	.out_slot_index (result.slot_index),
	.out_last       (result.last)
);

`default_nettype wire
